// File: hdl/bst_pkg.sv
// ----------------------------------------------------------------------------
// bst_pkg
// Shared types and character codes of the byte stream tokenizer.
// ----------------------------------------------------------------------------
package bst_pkg;

  localparam int unsigned MaxRes = 4;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_UNDER = 8'h5f;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_SLASH = 8'h2f;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_NUM,
    MODE_IDENT,
    MODE_STR,
    MODE_SLASH,
    MODE_CMT,
    MODE_CMT_STAR
  } mode_e;

  typedef enum logic [4:0] {
    TOK_NUMBER,
    TOK_FLOAT,
    TOK_STRING,
    TOK_ADD,
    TOK_SUB,
    TOK_MUL,
    TOK_DIV,
    TOK_MOD,
    TOK_GT,
    TOK_LT,
    TOK_EQ,
    TOK_LCURLY,
    TOK_RCURLY,
    TOK_LPAREN,
    TOK_RPAREN,
    TOK_LSQUARE,
    TOK_RSQUARE,
    TOK_KEYWORD,
    TOK_IDENT,
    TOK_COMMENT,
    TOK_EOF,
    TOK_COLON,
    TOK_SEMI,
    TOK_COMMA,
    TOK_DOT,
    TOK_DQUOTE,
    TOK_UNEXPECTED
  } tok_e;

  // one output result: value character or token end
  typedef struct packed {
    logic       kind;
    logic [7:0] value;
    tok_e       ttype;
  } res_t;

  // all results caused by one input byte
  typedef struct packed {
    logic [2:0]        n;
    res_t [MaxRes-1:0] r;
  } step_t;

endpackage

// File: hdl/bst_scanner.sv
// ----------------------------------------------------------------------------
// bst_scanner
// Scan state and per-byte result generation for the tokenizer.
// ----------------------------------------------------------------------------
module bst_scanner
  import bst_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] byte_i,
  output step_t      step_o
);

  mode_e mode_q, mode_d;
  logic  dot_q, dot_d;

  logic  byte_blank, byte_num, is_ident;
  logic  sc_hit;
  tok_e  sc_type;
  logic  do_between;

  function automatic step_t push(step_t s, logic kind, logic [7:0] v, tok_e t);
    step_t o;
    o = s;
    if (s.n < 3'(MaxRes)) begin
      o.r[s.n[1:0]] = '{kind: kind, value: v, ttype: t};
      o.n = s.n + 3'd1;
    end
    return o;
  endfunction

  assign byte_blank = (byte_i inside {8'h20, 8'h09, 8'h0d, 8'h0a});
  assign byte_num   = (byte_i inside {[8'h30:8'h39]});
  assign is_ident   = byte_num || (byte_i == CH_UNDER) ||
                      (byte_i inside {[8'h41:8'h5a], [8'h61:8'h7a]});

  // single-character tokens, end of input included
  always_comb begin
    sc_hit  = 1'b1;
    sc_type = TOK_EOF;
    case (byte_i)
      CH_NUL: sc_type = TOK_EOF;
      "=":    sc_type = TOK_EQ;
      ">":    sc_type = TOK_GT;
      "<":    sc_type = TOK_LT;
      "*":    sc_type = TOK_MUL;
      "%":    sc_type = TOK_MOD;
      "+":    sc_type = TOK_ADD;
      "-":    sc_type = TOK_SUB;
      "{":    sc_type = TOK_LCURLY;
      "}":    sc_type = TOK_RCURLY;
      "(":    sc_type = TOK_LPAREN;
      ")":    sc_type = TOK_RPAREN;
      "[":    sc_type = TOK_LSQUARE;
      "]":    sc_type = TOK_RSQUARE;
      ";":    sc_type = TOK_SEMI;
      ":":    sc_type = TOK_COLON;
      ",":    sc_type = TOK_COMMA;
      CH_DOT: sc_type = TOK_DOT;
      default: sc_hit = 1'b0;
    endcase
  end

  // byte falls through to the between-tokens handling
  always_comb begin
    case (mode_q)
      MODE_NUM:      do_between = !(byte_num || byte_i == CH_DOT);
      MODE_IDENT:    do_between = !is_ident;
      MODE_STR:      do_between = (byte_i == CH_NUL);
      MODE_SLASH:    do_between = (byte_i != CH_STAR);
      MODE_CMT:      do_between = (byte_i == CH_NUL);
      MODE_CMT_STAR: do_between = (byte_i == CH_NUL);
      default:       do_between = 1'b1;
    endcase
  end

  // next state
  always_comb begin
    mode_d = mode_q;
    dot_d  = dot_q;
    case (mode_q)
      MODE_NUM: begin
        if (byte_i == CH_DOT) begin
          dot_d = 1'b1;
        end else if (!byte_num) begin
          dot_d = 1'b0;
        end
      end
      MODE_STR: begin
        if (byte_i == CH_QUOTE) begin
          mode_d = MODE_IDLE;
        end
      end
      MODE_SLASH: begin
        if (byte_i == CH_STAR) begin
          mode_d = MODE_CMT;
        end
      end
      MODE_CMT: begin
        if (byte_i == CH_STAR) begin
          mode_d = MODE_CMT_STAR;
        end
      end
      MODE_CMT_STAR: begin
        if (byte_i == CH_SLASH) begin
          mode_d = MODE_IDLE;
        end else if (byte_i != CH_STAR) begin
          mode_d = MODE_CMT;
        end
      end
      default: ;
    endcase
    if (do_between) begin
      if (byte_blank || sc_hit) begin
        mode_d = MODE_IDLE;
      end else if (byte_i == CH_SLASH) begin
        mode_d = MODE_SLASH;
      end else if (byte_i == CH_QUOTE) begin
        mode_d = MODE_STR;
      end else if (byte_num) begin
        mode_d = MODE_NUM;
        dot_d  = 1'b0;
      end else if (is_ident) begin
        mode_d = MODE_IDENT;
      end else begin
        mode_d = MODE_IDLE;
      end
    end
  end

  // results of this byte
  always_comb begin
    step_t s;
    s = '0;
    case (mode_q)
      MODE_NUM: begin
        if (!do_between) begin
          s = push(s, 1'b0, byte_i, TOK_NUMBER);
        end else begin
          s = push(s, 1'b1, 8'h00, dot_q ? TOK_FLOAT : TOK_NUMBER);
        end
      end
      MODE_IDENT: begin
        if (!do_between) begin
          s = push(s, 1'b0, byte_i, TOK_NUMBER);
        end else begin
          s = push(s, 1'b1, 8'h00, TOK_IDENT);
        end
      end
      MODE_STR: begin
        if (byte_i == CH_QUOTE || byte_i == CH_NUL) begin
          s = push(s, 1'b1, 8'h00, TOK_STRING);
        end else begin
          s = push(s, 1'b0, byte_i, TOK_NUMBER);
        end
      end
      MODE_SLASH: begin
        if (do_between) begin
          s = push(s, 1'b0, CH_SLASH, TOK_NUMBER);
          s = push(s, 1'b1, 8'h00, TOK_DIV);
        end
      end
      MODE_CMT: begin
        if (byte_i == CH_NUL) begin
          s = push(s, 1'b1, 8'h00, TOK_COMMENT);
        end else if (byte_i != CH_STAR) begin
          s = push(s, 1'b0, byte_i, TOK_NUMBER);
        end
      end
      MODE_CMT_STAR: begin
        if (byte_i == CH_SLASH) begin
          s = push(s, 1'b1, 8'h00, TOK_COMMENT);
        end else if (byte_i == CH_STAR) begin
          s = push(s, 1'b0, CH_STAR, TOK_NUMBER);
        end else if (byte_i == CH_NUL) begin
          s = push(s, 1'b0, CH_STAR, TOK_NUMBER);
          s = push(s, 1'b1, 8'h00, TOK_COMMENT);
        end else begin
          // star that did not close the comment is content
          s = push(s, 1'b0, CH_STAR, TOK_NUMBER);
          s = push(s, 1'b0, byte_i, TOK_NUMBER);
        end
      end
      default: ;
    endcase
    if (do_between && !byte_blank) begin
      if (sc_hit) begin
        s = push(s, 1'b0, byte_i, TOK_NUMBER);
        s = push(s, 1'b1, 8'h00, sc_type);
      end else if (byte_i == CH_SLASH || byte_i == CH_QUOTE) begin
        s = s;
      end else if (is_ident) begin
        s = push(s, 1'b0, byte_i, TOK_NUMBER);
      end else begin
        s = push(s, 1'b1, 8'h00, TOK_UNEXPECTED);
      end
    end
    step_o = s;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      dot_q  <= 1'b0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      dot_q  <= dot_d;
    end
  end

endmodule

// File: hdl/byte_stream_tokenizer.sv
// ----------------------------------------------------------------------------
// byte_stream_tokenizer
// Cuts a source byte stream into tokens, streamed as value characters and
// a token end carrying the token type.
// ----------------------------------------------------------------------------
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_ready_o | in_byte_i
//   out     | output    | out_valid_o/out_ready_i | out_kind_o, value_byte_o,
//           |           |                         | token_type_o, last_o
//
// a byte is scanned in the cycle it is taken; its 0 to 4 results are held
// in a four-entry result buffer and leave one per cycle through the single
// output port while out_ready_i is high
// the next byte is taken in the cycle the last buffered result leaves
// reset returns the scanner to idle between tokens and empties the buffer
// a stalled output holds the current result and blocks further input
// ----------------------------------------------------------------------------
module byte_stream_tokenizer
  import bst_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       out_kind_o,
  output logic [7:0] value_byte_o,
  output logic [4:0] token_type_o,
  output logic       last_o
);

  step_t      step;
  res_t       buf_q [MaxRes];
  logic [2:0] rem_q, rem_d;
  logic [1:0] rd_q, rd_d;
  logic       in_acc, out_acc;
  res_t       cur;

  bst_scanner u_scanner (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_acc),
    .byte_i   (in_byte_i),
    .step_o   (step)
  );

  assign out_valid_o = (rem_q != 3'd0);
  assign out_acc     = out_valid_o && out_ready_i;
  assign in_ready_o  = (rem_q == 3'd0) || (rem_q == 3'd1 && out_ready_i);
  assign in_acc      = in_valid_i && in_ready_o;

  assign cur          = buf_q[rd_q];
  assign out_kind_o   = cur.kind;
  assign value_byte_o = cur.value;
  assign token_type_o = cur.ttype;
  assign last_o       = (rem_q == 3'd1);

  always_comb begin
    rem_d = rem_q;
    rd_d  = rd_q;
    if (in_acc) begin
      rem_d = step.n;
      rd_d  = 2'd0;
    end else if (out_acc) begin
      rem_d = rem_q - 3'd1;
      rd_d  = rd_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 3'd0;
      rd_q  <= 2'd0;
    end else begin
      rem_q <= rem_d;
      rd_q  <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int i = 0; i < MaxRes; i++) begin
        buf_q[i] <= step.r[i];
      end
    end
  end

  a_rem_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= 3'(MaxRes))
    else $error("result count beyond buffer depth");

  a_busy_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q > 3'd1 |-> !in_ready_o)
    else $error("input taken while results still pending");

  a_res_follow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && step.n != 3'd0 |=> out_valid_o && rd_q == 2'd0)
    else $error("results of accepted byte not presented");

  a_end_coding : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o |-> value_byte_o == 8'h00)
    else $error("token end carries a value character");

endmodule

// File: sim/token_checker.sv
// ----------------------------------------------------------------------------
// token_checker
// Watches both channels of the byte stream tokenizer. It predicts the
// value characters and token ends of every accepted source byte and
// compares each result leaving the block against the oldest prediction.
// ----------------------------------------------------------------------------
module token_checker
  import bst_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] in_byte_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic       out_kind_i,
  input  logic [7:0] value_byte_i,
  input  logic [4:0] token_type_i,
  input  logic       last_i,
  output int         fail_cnt_o,
  output int         pending_o
);

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef struct packed {
    logic       kind;
    logic [7:0] value;
    tok_e       ttype;
    logic       last;
  } token_res_t;

  mode_e      scan_mode = MODE_IDLE;
  logic       saw_dot   = 1'b0;
  token_res_t token_q[$];
  token_res_t byte_res[MaxRes];
  int         byte_res_n;
  token_res_t want;
  int         n_fail = 0;

  function automatic logic num_char(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_ident_char(logic [7:0] c);
    return c == CH_UNDER || num_char(c) || (c >= "A" && c <= "Z") ||
           (c >= "a" && c <= "z");
  endfunction

  function automatic logic blank_char(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
  endfunction

  task automatic add_res(logic kind, logic [7:0] value, tok_e ttype);
    if (byte_res_n < MaxRes) begin
      byte_res[byte_res_n] = '{kind, value, ttype, 1'b0};
      byte_res_n++;
    end
  endtask

  task automatic add_char(logic [7:0] c);
    add_res(1'b0, c, TOK_NUMBER);
  endtask

  task automatic add_end(tok_e ttype);
    add_res(1'b1, 8'h00, ttype);
  endtask

  task automatic add_single(logic [7:0] c, tok_e ttype);
    add_char(c);
    add_end(ttype);
  endtask

  // first byte between tokens
  task automatic scan_between(logic [7:0] c);
    scan_mode = MODE_IDLE;
    if (!blank_char(c)) begin
      case (c)
        CH_NUL:   add_single(CH_NUL, TOK_EOF);
        "=":      add_single(c, TOK_EQ);
        ">":      add_single(c, TOK_GT);
        "<":      add_single(c, TOK_LT);
        CH_SLASH: scan_mode = MODE_SLASH;
        CH_STAR:  add_single(c, TOK_MUL);
        "%":      add_single(c, TOK_MOD);
        "+":      add_single(c, TOK_ADD);
        "-":      add_single(c, TOK_SUB);
        "{":      add_single(c, TOK_LCURLY);
        "}":      add_single(c, TOK_RCURLY);
        "(":      add_single(c, TOK_LPAREN);
        ")":      add_single(c, TOK_RPAREN);
        "[":      add_single(c, TOK_LSQUARE);
        "]":      add_single(c, TOK_RSQUARE);
        ";":      add_single(c, TOK_SEMI);
        ":":      add_single(c, TOK_COLON);
        ",":      add_single(c, TOK_COMMA);
        CH_DOT:   add_single(c, TOK_DOT);
        CH_QUOTE: scan_mode = MODE_STR;
        default: begin
          if (num_char(c)) begin
            scan_mode = MODE_NUM;
            saw_dot   = 1'b0;
            add_char(c);
          end else if (is_ident_char(c)) begin
            scan_mode = MODE_IDENT;
            add_char(c);
          end else begin
            add_end(TOK_UNEXPECTED);
          end
        end
      endcase
    end
  endtask

  task automatic tokenize_byte(logic [7:0] c);
    byte_res_n = 0;
    case (scan_mode)
      MODE_NUM: begin
        if (num_char(c) || c == CH_DOT) begin
          if (c == CH_DOT) saw_dot = 1'b1;
          add_char(c);
        end else begin
          add_end(saw_dot ? TOK_FLOAT : TOK_NUMBER);
          saw_dot = 1'b0;
          scan_between(c);
        end
      end
      MODE_IDENT: begin
        if (is_ident_char(c)) begin
          add_char(c);
        end else begin
          add_end(TOK_IDENT);
          scan_between(c);
        end
      end
      MODE_STR: begin
        if (c == CH_QUOTE) begin
          add_end(TOK_STRING);
          scan_mode = MODE_IDLE;
        end else if (c == CH_NUL) begin
          add_end(TOK_STRING);
          scan_between(c);
        end else begin
          add_char(c);
        end
      end
      MODE_SLASH: begin
        if (c == CH_STAR) begin
          scan_mode = MODE_CMT;
        end else begin
          add_single(CH_SLASH, TOK_DIV);
          scan_between(c);
        end
      end
      MODE_CMT: begin
        if (c == CH_STAR) begin
          scan_mode = MODE_CMT_STAR;
        end else if (c == CH_NUL) begin
          add_end(TOK_COMMENT);
          scan_between(c);
        end else begin
          add_char(c);
        end
      end
      MODE_CMT_STAR: begin
        if (c == CH_SLASH) begin
          add_end(TOK_COMMENT);
          scan_mode = MODE_IDLE;
        end else if (c == CH_STAR) begin
          add_char(CH_STAR);
        end else if (c == CH_NUL) begin
          add_char(CH_STAR);
          add_end(TOK_COMMENT);
          scan_between(c);
        end else begin
          // pending star was plain comment text
          add_char(CH_STAR);
          add_char(c);
          scan_mode = MODE_CMT;
        end
      end
      default: scan_between(c);
    endcase
    if (byte_res_n > 0) byte_res[byte_res_n-1].last = 1'b1;
    for (int i = 0; i < byte_res_n; i++) token_q.push_back(byte_res[i]);
  endtask

  task automatic check_field(string name, logic [7:0] want_v, logic [7:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      n_fail++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_mode = MODE_IDLE;
      saw_dot   = 1'b0;
      token_q.delete();
      n_fail    = 0;
      fail_cnt_o <= 0;
      pending_o  <= 0;
    end else begin
      // new request first; a result leaving in the same cycle is from an earlier byte
      if (in_valid_i && in_ready_i) tokenize_byte(in_byte_i);
      if (out_valid_i && out_ready_i) begin
        if (token_q.size() == 0) begin
          $error("result with nothing pending: kind %0d value %0d type %0d last %0d",
                 out_kind_i, value_byte_i, token_type_i, last_i);
          n_fail++;
        end else begin
          want = token_q.pop_front();
          check_field("out_kind", want.kind, out_kind_i);
          check_field("value_byte", want.value, value_byte_i);
          check_field("token_type", want.ttype, token_type_i);
          check_field("last", want.last, last_i);
        end
      end
      fail_cnt_o <= n_fail;
      pending_o  <= token_q.size();
    end
  end

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Feeds the byte stream tokenizer a short directed text and then random
// token sequences, idle gaps and noise, with a stalling receiver. A
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top
  import bst_pkg::*;
();

  localparam int NumBytes = 420;
  localparam int HoldFrom = 300;
  localparam int HoldLen  = 120;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] in_byte_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic       out_kind_o;
  logic [7:0] value_byte_o;
  logic [4:0] token_type_o;
  logic       last_o;
  int         fail_cnt;
  int         pending_cnt;
  int         rx_cycle = 0;

  byte_stream_tokenizer dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_byte_i    (in_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_kind_o   (out_kind_o),
    .value_byte_o (value_byte_o),
    .token_type_o (token_type_o),
    .last_o       (last_o)
  );

  token_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_byte_i    (in_byte_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_kind_i   (out_kind_o),
    .value_byte_i (value_byte_o),
    .token_type_i (token_type_o),
    .last_i       (last_o),
    .fail_cnt_o   (fail_cnt),
    .pending_o    (pending_cnt)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  // receiver: rotates through four ready patterns, one without stalls, plus one long hold-off
  initial out_ready_i = 1'b0;
  always @(posedge clk_i) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle >= HoldFrom && rx_cycle < HoldFrom + HoldLen) begin
      out_ready_i <= 1'b0;
    end else begin
      case ((rx_cycle / 50) % 4)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= 1'($urandom_range(0, 1));
        2:       out_ready_i <= ($urandom_range(0, 3) == 0);
        default: out_ready_i <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  function automatic logic [7:0] pick_ident_char(bit with_digits);
    int unsigned r;
    r = $urandom_range(0, with_digits ? 62 : 52);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r == 52) return CH_UNDER;
    return 8'("0" + r - 53);
  endfunction

  // any byte a string may hold
  function automatic logic [7:0] pick_text_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (b == CH_QUOTE);
    return b;
  endfunction

  initial begin
    string      directed;
    string      ops;
    string      blanks;
    logic [7:0] src_q[$];
    int         sel;
    int         len;
    int         burst_left;
    int         gap;
    int         pause_at;

    in_valid_i = 1'b0;
    in_byte_i  = 8'h00;
    rst_ni     = 1'b0;

    // identifier closed by an operator, float closed by an operator, comment
    // with a slash after the opening star and doubled stars, string,
    // division right before modulo, leading dot, unexpected bytes, and a
    // number closed by end of input
    directed = "_9=1.2>/*/x**/\"q\"/%.@";
    for (int i = 0; i < directed.len(); i++) src_q.push_back(directed[i]);
    src_q.push_back(8'hff);
    src_q.push_back(8'h09);
    src_q.push_back("5");
    src_q.push_back(CH_NUL);

    ops    = "=><*%+-{}()[];:,.";
    blanks = " \t\r\n";
    while (src_q.size() < NumBytes) begin
      sel = $urandom_range(0, 99);
      len = $urandom_range(0, 6);
      if (sel < 15) begin
        src_q.push_back(pick_ident_char(1'b0));
        repeat (len) src_q.push_back(pick_ident_char(1'b1));
      end else if (sel < 30) begin
        src_q.push_back(8'("0" + $urandom_range(0, 9)));
        repeat (len) begin
          if ($urandom_range(0, 4) == 0) src_q.push_back(CH_DOT);
          else src_q.push_back(8'("0" + $urandom_range(0, 9)));
        end
      end else if (sel < 48) begin
        src_q.push_back(ops[$urandom_range(0, ops.len() - 1)]);
      end else if (sel < 58) begin
        src_q.push_back(CH_QUOTE);
        repeat (len) src_q.push_back(pick_text_byte());
        src_q.push_back(CH_QUOTE);
      end else if (sel < 66) begin
        src_q.push_back(CH_SLASH);
        src_q.push_back(CH_STAR);
        repeat (len) begin
          if ($urandom_range(0, 2) == 0) src_q.push_back(CH_STAR);
          else src_q.push_back(8'($urandom_range(1, 255)));
        end
        src_q.push_back(CH_STAR);
        src_q.push_back(CH_SLASH);
      end else if (sel < 74) begin
        src_q.push_back(blanks[$urandom_range(0, blanks.len() - 1)]);
      end else if (sel < 80) begin
        src_q.push_back(CH_SLASH);
      end else if (sel < 88) begin
        src_q.push_back(8'($urandom_range(1, 255)));
      end else if (sel < 96) begin
        // token left open at end of input
        case ($urandom_range(0, 3))
          0: begin
            src_q.push_back(CH_QUOTE);
            repeat (len) src_q.push_back(pick_text_byte());
          end
          1: begin
            src_q.push_back(CH_SLASH);
            src_q.push_back(CH_STAR);
            repeat (len) src_q.push_back(pick_ident_char(1'b1));
          end
          2: src_q.push_back(CH_SLASH);
          default: begin
            src_q.push_back(CH_SLASH);
            src_q.push_back(CH_STAR);
            src_q.push_back(pick_ident_char(1'b0));
            src_q.push_back(CH_STAR);
          end
        endcase
        src_q.push_back(CH_NUL);
      end else begin
        src_q.push_back(CH_NUL);
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    pause_at   = (src_q.size() * 3) / 4;
    burst_left = 0;
    foreach (src_q[i]) begin
      if (i == pause_at) begin
        // drain everything before going on
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (pending_cnt != 0) @(posedge clk_i);
      end else if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        if (gap != 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      if (burst_left > 0) burst_left--;
      in_valid_i <= 1'b1;
      in_byte_i  <= src_q[i];
      do @(posedge clk_i); while (!in_ready_o);
    end
    in_valid_i <= 1'b0;

    // pending count of the last request shows in the following cycle
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/bst_pkg.sv
hdl/bst_scanner.sv
hdl/byte_stream_tokenizer.sv
sim/token_checker.sv
sim/tb_top.sv
